FILE: src/g7pd_pkg.sv
`timescale 1ns / 1ps
// shared constants and result type for the group-of-seven packet decoder
package g7pd_pkg;

	localparam int unsigned POS_W   = 11;
	localparam int unsigned COUNT_W = 10;

	localparam logic [POS_W-1:0] HEADER_LEN  = 11'd7;
	localparam logic [POS_W-1:0] ODD_CNT_POS = 11'd5;
	localparam logic [POS_W-1:0] GRP_CNT_POS = 11'd6;
	localparam logic [POS_W-1:0] ODD_MSB_POS = 11'd7;
	localparam logic [POS_W-1:0] FIRST_ODD   = 11'd8;
	localparam logic [POS_W-1:0] POS_MAX     = 11'd2047;

	localparam logic [7:0] LOW7_MASK = 8'h7f;
	localparam logic [7:0] EVEN_MASK = 8'h55;
	localparam logic [6:0] ODD_LIMIT = 7'd6;

	typedef struct packed {
		logic [7:0]         data_byte;
		logic               is_status;
		logic               checksum_ok;
		logic               format_error;
		logic [COUNT_W-1:0] data_count;
	} result_t;

endpackage

FILE: src/g7pd_decode.sv
`timescale 1ns / 1ps
// packet state and single-pass decode of one byte
module g7pd_decode (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              step,
	input  logic [7:0]        byte_in,
	input  logic              start_in,
	output logic              res_valid,
	output g7pd_pkg::result_t res
);
	import g7pd_pkg::*;

	logic [POS_W-1:0]   pos_q;
	logic [6:0]         odd_q;
	logic [6:0]         grp_q;
	logic [7:0]         odd_msb_q;
	logic [7:0]         grp_msb_q;
	logic [7:0]         cks_q;
	logic [7:0]         even_q;
	logic [COUNT_W-1:0] done_q;

	// state as seen by this byte: a start clears everything first
	logic [POS_W-1:0]   pos;
	logic [6:0]         odd;
	logic [6:0]         grp;
	logic [7:0]         odd_msb;
	logic [7:0]         grp_msb;
	logic [7:0]         cks;
	logic [7:0]         even;
	logic [COUNT_W-1:0] done;

	logic [6:0]         odd_n;
	logic [6:0]         grp_n;
	logic [7:0]         odd_msb_n;
	logic [7:0]         grp_msb_n;
	logic [7:0]         cks_n;
	logic [7:0]         even_n;
	logic [COUNT_W-1:0] done_n;

	logic [POS_W-1:0]   gstart;
	logic [POS_W-1:0]   chk;
	logic [POS_W-1:0]   odd_k;
	logic [2:0]         grp_j;
	logic [7:0]         rebuilt;
	logic [7:0]         received;
	logic               emit;

	assign pos     = start_in ? '0 : pos_q;
	assign odd     = start_in ? '0 : odd_q;
	assign grp     = start_in ? '0 : grp_q;
	assign odd_msb = start_in ? '0 : odd_msb_q;
	assign grp_msb = start_in ? '0 : grp_msb_q;
	assign cks     = start_in ? '0 : cks_q;
	assign even    = start_in ? '0 : even_q;
	assign done    = start_in ? '0 : done_q;

	assign gstart   = HEADER_LEN + POS_W'(odd) + POS_W'(odd != '0);
	assign chk      = gstart + {1'b0, grp, 3'b000};
	assign odd_k    = pos - FIRST_ODD;
	assign grp_j    = 3'(pos - gstart);
	assign received = even | 8'((byte_in & EVEN_MASK) << 1);

	always_comb begin
		odd_n     = odd;
		grp_n     = grp;
		odd_msb_n = odd_msb;
		grp_msb_n = grp_msb;
		cks_n     = cks;
		even_n    = even;
		done_n    = done;
		emit      = 1'b0;
		rebuilt   = {1'b0, byte_in[6:0]};
		res_valid = 1'b0;
		res       = '0;
		if (pos < HEADER_LEN) begin
			cks_n = cks ^ byte_in;
			if (pos == ODD_CNT_POS) begin
				odd_n = byte_in[6:0];
			end else if (pos == GRP_CNT_POS) begin
				grp_n = byte_in[6:0];
			end
		end else if (odd != '0 && pos == ODD_MSB_POS) begin
			odd_msb_n = byte_in;
		end else if (pos < gstart) begin
			// odd bytes past the seventh have no msb source
			if (odd_k <= POS_W'(ODD_LIMIT)) begin
				rebuilt[7] = odd_msb[3'd6 - odd_k[2:0]];
			end
			emit = 1'b1;
		end else if (pos < chk) begin
			if (grp_j == 3'd0) begin
				grp_msb_n = byte_in;
			end else begin
				rebuilt[7] = grp_msb[3'd7 - grp_j];
				emit       = 1'b1;
			end
		end else if (pos == chk) begin
			even_n = byte_in & EVEN_MASK;
		end else if (pos == chk + 11'd1) begin
			res_valid        = 1'b1;
			res.is_status    = 1'b1;
			res.checksum_ok  = (received == cks);
			res.format_error = (odd > ODD_LIMIT);
			res.data_count   = done;
		end
		if (emit) begin
			cks_n         = cks ^ rebuilt;
			done_n        = done + 10'd1;
			res_valid     = 1'b1;
			res.data_byte = rebuilt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q     <= '0;
			odd_q     <= '0;
			grp_q     <= '0;
			odd_msb_q <= '0;
			grp_msb_q <= '0;
			cks_q     <= '0;
			even_q    <= '0;
			done_q    <= '0;
		end else if (step) begin
			pos_q     <= (pos == POS_MAX) ? pos : pos + 11'd1;
			odd_q     <= odd_n;
			grp_q     <= grp_n;
			odd_msb_q <= odd_msb_n;
			grp_msb_q <= grp_msb_n;
			cks_q     <= cks_n;
			even_q    <= even_n;
			done_q    <= done_n;
		end
	end

`ifndef SYNTH
	a_pos_advance: assert property (@(posedge clk) disable iff (!arst_n)
		step && !start_in && pos_q != POS_MAX |=> pos_q == $past(pos_q) + 11'd1)
		else $error("byte position did not advance");

	a_data_clean: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res.is_status |->
			!res.checksum_ok && !res.format_error && res.data_count == '0)
		else $error("data result carries status fields");

	a_count_data: assert property (@(posedge clk) disable iff (!arst_n)
		step && res_valid && !res.is_status |=> done_q == $past(done) + 10'd1)
		else $error("data count missed a data byte");
`endif

endmodule

FILE: src/g7pd_result_reg.sv
`timescale 1ns / 1ps
// output register holding one result until its transfer
module g7pd_result_reg (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              load_valid,
	input  g7pd_pkg::result_t load_res,
	output logic              ready,
	output logic              out_valid,
	input  logic              out_stall,
	output g7pd_pkg::result_t out_res
);
	import g7pd_pkg::*;

	logic    valid_q;
	result_t res_q;

	assign ready     = !valid_q || !out_stall;
	assign out_valid = valid_q;
	assign out_res   = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ready) begin
			valid_q <= load_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (ready && load_valid) begin
			res_q <= load_res;
		end
	end

endmodule

FILE: src/group_of_seven_packet_decoder_core.sv
`timescale 1ns / 1ps
// top level of the group-of-seven packet decoder
//
//  channel  direction  handshake          payload
//  in       input      in_valid/in_stall  packet_byte, start_req
//  out      output     out_valid/out_stall data_byte, is_status, checksum_ok,
//                                          format_error, data_count
//
// one byte per cycle while the output is not stalled; a byte is held in the input
// register, then decoded into the output register, from which its result is offered
// reset clears the decoder so the first byte is taken as the first header byte
// a stalled output holds its result while one more byte waits in the input register
module group_of_seven_packet_decoder_core (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic [7:0]                      packet_byte,
	input  logic                            start_req,
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic [7:0]                      data_byte,
	output logic                            is_status,
	output logic                            checksum_ok,
	output logic                            format_error,
	output logic [g7pd_pkg::COUNT_W-1:0]    data_count
);
	import g7pd_pkg::*;

	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       start_s1;
	logic       out_ready;
	logic       step;
	logic       res_valid;
	result_t    res;
	result_t    out_res;

	assign in_stall = valid_s1 && !out_ready;
	assign step     = valid_s1 && out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!in_stall && in_valid) begin
			byte_s1  <= packet_byte;
			start_s1 <= start_req;
		end
	end

	g7pd_decode u_decode (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (step),
		.byte_in   (byte_s1),
		.start_in  (start_s1),
		.res_valid (res_valid),
		.res       (res)
	);

	g7pd_result_reg u_result (
		.clk        (clk),
		.arst_n     (arst_n),
		.load_valid (step && res_valid),
		.load_res   (res),
		.ready      (out_ready),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.out_res    (out_res)
	);

	assign data_byte    = out_res.data_byte;
	assign is_status    = out_res.is_status;
	assign checksum_ok  = out_res.checksum_ok;
	assign format_error = out_res.format_error;
	assign data_count   = out_res.data_count;

endmodule
